// ===== design/sorted_list_table_assert.svh =====
// assertion helpers shared by the checker
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted list table check failed");

// consequent in the cycle after the antecedent
`define SLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted list table check failed");

`endif

// ===== design/slt_pkg.sv =====
package slt_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int IN_VALUE_W      = 16;
	localparam int POS_W           = 5;
	localparam int COUNT_OUT_W     = 5;

	typedef enum logic [1:0] {
		CMD_INSERT    = 2'd0,
		CMD_DEL_VALUE = 2'd1,
		CMD_DEL_POS   = 2'd2,
		CMD_NOP       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NOT_FOUND    = 2'd1,
		ST_OUT_OF_RANGE = 2'd2,
		ST_FULL         = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DEL_POS,
		OP_DEL_VAL
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   pos;
	} cell_ctrl_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [IN_VALUE_W-1:0] value;
		logic [POS_W-1:0]      position;
	} command_t;

	typedef struct packed {
		status_t                status;
		logic [COUNT_OUT_W-1:0] entry_count;
	} result_t;

endpackage

// ===== design/slt_cell.sv =====
module slt_cell import slt_pkg::*; #(
	parameter int IDX         = 0,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int CNT_W       = 5
) (
	input  logic                   clk,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [CNT_W-1:0]       count,
	input  cell_ctrl_t             ctrl,
	input  logic [VALUE_WIDTH-1:0] left_entry,
	input  logic                   left_lt,
	input  logic [VALUE_WIDTH-1:0] right_entry,
	output logic [VALUE_WIDTH-1:0] entry,
	output logic                   lt,
	output logic                   eq
);

	localparam int PW = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   lt_q;
	logic                   eq_q;
	logic                   active;
	logic                   at_or_after_pos;

	assign active          = CNT_W'(IDX) < count;
	// 1-based position: this cell and all above it move down
	assign at_or_after_pos = PW'(IDX + 1) >= PW'(ctrl.pos);

	always_ff @(posedge clk) begin
		lt_q <= active && (entry_q < value);
		eq_q <= active && (entry_q == value);
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (!lt_q) begin
					entry_q <= left_lt ? value : left_entry;
				end
			end
			OP_DEL_POS: begin
				if (at_or_after_pos) begin
					entry_q <= right_entry;
				end
			end
			OP_DEL_VAL: begin
				// the match run starts at the first cell not below the value
				if (!lt_q) begin
					entry_q <= right_entry;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

// ===== design/sorted_list_table.sv =====
// channel   direction  handshake            payload
// command   in         start && !busy       command_t: cmd, value, position
// result    out        done, one cycle      result_t: status, entry_count
//
// insert, delete by position and the unused code run a compare cycle in every
// cell, then a shift cycle along the cell chain.
// delete by value repeats the compare/shift pair: each pair
// removes one matching entry, the last pair finds none left.
// the result strobe comes in the cycle after the last shift, with busy low,
// so the next command can be taken in that cycle; the receiver cannot stall.
// reset clears the entry count and the controller; the cells hold no reset.
module sorted_list_table import slt_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  command_t command,
	output logic     done,
	output result_t  result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	state_t                 state_q, state_d;
	cmd_t                   cmd_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       count_q, count_d;
	logic                   removed_q;
	logic                   done_q;
	result_t                result_q;

	logic [VALUE_WIDTH+IN_VALUE_W-1:0] value_wide;
	logic                   accept;
	logic                   any_eq;
	logic                   finish;
	logic                   full;
	logic                   pos_ok;
	status_t                status_d;
	cell_ctrl_t             ctrl;
	logic [PW-1:0]          count_ext;

	logic [VALUE_WIDTH-1:0] entry_vec [CAPACITY];
	logic [CAPACITY-1:0]    lt_vec;
	logic [CAPACITY-1:0]    eq_vec;

	assign accept     = start && !busy;
	assign value_wide = {VALUE_WIDTH'(0), command.value};
	assign any_eq     = |eq_vec;
	assign full       = count_q >= CNT_W'(CAPACITY);
	assign pos_ok     = (pos_q != '0) && (PW'(pos_q) <= PW'(count_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			removed_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= finish;
			if (accept) begin
				removed_q <= 1'b0;
			end else if (ctrl.op == OP_DEL_VAL) begin
				removed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command.cmd;
			value_q <= value_wide[VALUE_WIDTH-1:0];
			pos_q   <= command.position;
		end
		if (finish) begin
			result_q.status      <= status_d;
			result_q.entry_count <= count_ext[COUNT_OUT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				state_d = (cmd_q == CMD_DEL_VALUE && any_eq) ? S_CMP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy     = state_q != S_IDLE;
		ctrl.op  = OP_HOLD;
		ctrl.pos = pos_q;
		finish   = 1'b0;
		status_d = ST_OK;
		count_d  = count_q;
		if (state_q == S_APPLY) begin
			finish = 1'b1;
			case (cmd_q)
				CMD_INSERT: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctrl.op = OP_INSERT;
						count_d = count_q + 1'b1;
					end
				end
				CMD_DEL_POS: begin
					if (pos_ok) begin
						ctrl.op = OP_DEL_POS;
						count_d = count_q - 1'b1;
					end else begin
						status_d = ST_OUT_OF_RANGE;
					end
				end
				CMD_DEL_VALUE: begin
					if (any_eq) begin
						// one match out per pass, compare again after the shift
						ctrl.op = OP_DEL_VAL;
						count_d = count_q - 1'b1;
						finish  = 1'b0;
					end else if (!removed_q) begin
						status_d = ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign count_ext = PW'(count_d);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_entry;
		logic                   left_lt;
		logic [VALUE_WIDTH-1:0] right_entry;

		if (i == 0) begin : g_head
			assign left_entry = value_q;
			assign left_lt    = 1'b1;
		end else begin : g_body
			assign left_entry = entry_vec[i-1];
			assign left_lt    = lt_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entry_vec[i];
		end else begin : g_next
			assign right_entry = entry_vec[i+1];
		end

		slt_cell #(
			.IDX         (i),
			.VALUE_WIDTH (VALUE_WIDTH),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk         (clk),
			.value       (value_q),
			.count       (count_q),
			.ctrl        (ctrl),
			.left_entry  (left_entry),
			.left_lt     (left_lt),
			.right_entry (right_entry),
			.entry       (entry_vec[i]),
			.lt          (lt_vec[i]),
			.eq          (eq_vec[i])
		);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== design/slt_checker.sv =====
`include "sorted_list_table_assert.svh"

module slt_checker import slt_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input command_t command,
	input logic     done,
	input result_t  result
);

	// a transfer always starts a compare cycle
	`SLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// no result can follow a transfer directly
	`SLT_ASSERT_NEXT(a_accept_no_done, start && !busy, !done)
	// the result comes with the block already free
	`SLT_ASSERT_NOW(a_done_idle, done, !busy)
	// every finished command shows its result
	`SLT_ASSERT_NOW(a_fell_done, $fell(busy), done)

endmodule

bind sorted_list_table slt_checker u_checker (.*);
